/* rtl/core/pta_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the port table allocator.
package pta_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = ADDR_W + 1;

	localparam logic [15:0] RESET_GENERAL_BASE  = 16'd5000;
	localparam logic [15:0] RESET_GENERAL_LIMIT = 16'd30000;
	localparam logic [15:0] RESET_PRIV_BASE     = 16'd600;
	localparam logic [15:0] RESET_PRIV_LIMIT    = 16'd1024;

	localparam logic [2:0] OP_LOOKUP     = 3'd0;
	localparam logic [2:0] OP_BIND       = 3'd1;
	localparam logic [2:0] OP_AUTO       = 3'd2;
	localparam logic [2:0] OP_SET_REMOTE = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_IN_USE    = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_MISS      = 2'd3;

	localparam logic [1:0] CFG_GENERAL_BASE  = 2'd0;
	localparam logic [1:0] CFG_GENERAL_LIMIT = 2'd1;
	localparam logic [1:0] CFG_PRIV_BASE     = 2'd2;
	localparam logic [1:0] CFG_PRIV_LIMIT    = 2'd3;

	typedef enum logic [1:0] {KEY_LOOKUP, KEY_PORT, KEY_CAND} key_t;
	typedef enum logic [1:0] {RP_ZERO, RP_PORT, RP_CAND} rp_sel_t;

	typedef struct packed {
		logic       capture;
		logic       scan_start;
		logic       scan_run;
		key_t       key;
		logic       cand_init;
		logic       cand_seg1;
		logic       cand_inc;
		logic       wr_local;
		logic       clr_local;
		logic       wr_remote;
		logic       clr_entry;
		logic       cursor_upd;
		logic       respond;
		logic [1:0] resp_status;
		rp_sel_t    rp_sel;
		logic       me_hit;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       ent_ok;
		logic       port_zero;
		logic       scan_done;
		logic       hit;
		logic       cand_in_seg;
		logic       cand_zero;
		logic       seg1;
	} sts_t;

endpackage

/* rtl/core/pta_ctrl.sv */
// Controller state machine sequencing decode, table scans and the auto-bind candidate walk.
module pta_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pta_pkg::sts_t sts,
	output pta_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN_LK, S_SCAN_BIND, S_CAND, S_SCAN_AUTO}
		state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.key     = pta_pkg::KEY_LOOKUP;
		cmd.rp_sel  = pta_pkg::RP_ZERO;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == pta_pkg::OP_LOOKUP) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN_LK;
				end else if (sts.op > pta_pkg::OP_CLEAR || !sts.ent_ok) begin
					cmd.respond     = 1'b1;
					cmd.resp_status = pta_pkg::ST_OK;
					state_d         = S_IDLE;
				end else if (sts.op == pta_pkg::OP_BIND) begin
					if (sts.port_zero) begin
						cmd.clr_local   = 1'b1;
						cmd.respond     = 1'b1;
						cmd.resp_status = pta_pkg::ST_OK;
						state_d         = S_IDLE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN_BIND;
					end
				end else if (sts.op == pta_pkg::OP_AUTO) begin
					cmd.cand_init = 1'b1;
					state_d       = S_CAND;
				end else begin
					cmd.wr_remote   = (sts.op == pta_pkg::OP_SET_REMOTE);
					cmd.clr_entry   = (sts.op == pta_pkg::OP_CLEAR);
					cmd.respond     = 1'b1;
					cmd.resp_status = pta_pkg::ST_OK;
					state_d         = S_IDLE;
				end
			end
			S_SCAN_LK: begin
				cmd.scan_run = 1'b1;
				cmd.key      = pta_pkg::KEY_LOOKUP;
				if (sts.scan_done) begin
					cmd.respond     = 1'b1;
					cmd.resp_status = sts.hit ? pta_pkg::ST_OK : pta_pkg::ST_MISS;
					cmd.me_hit      = sts.hit;
					state_d         = S_IDLE;
				end
			end
			S_SCAN_BIND: begin
				cmd.scan_run = 1'b1;
				cmd.key      = pta_pkg::KEY_PORT;
				if (sts.scan_done) begin
					cmd.respond = 1'b1;
					if (sts.hit) begin
						cmd.resp_status = pta_pkg::ST_IN_USE;
					end else begin
						cmd.wr_local    = 1'b1;
						cmd.resp_status = pta_pkg::ST_OK;
						cmd.rp_sel      = pta_pkg::RP_PORT;
					end
					state_d = S_IDLE;
				end
			end
			S_CAND: begin
				if (!sts.cand_in_seg) begin
					if (sts.seg1) begin
						cmd.respond     = 1'b1;
						cmd.resp_status = pta_pkg::ST_EXHAUSTED;
						state_d         = S_IDLE;
					end else begin
						cmd.cand_seg1 = 1'b1;
					end
				end else if (sts.cand_zero) begin
					cmd.cand_inc = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN_AUTO;
				end
			end
			S_SCAN_AUTO: begin
				cmd.scan_run = 1'b1;
				cmd.key      = pta_pkg::KEY_CAND;
				if (sts.scan_done) begin
					if (sts.hit) begin
						// candidate held: advance and try the next one
						cmd.cand_inc = 1'b1;
						state_d      = S_CAND;
					end else begin
						cmd.wr_local    = 1'b1;
						cmd.cursor_upd  = 1'b1;
						cmd.respond     = 1'b1;
						cmd.resp_status = pta_pkg::ST_OK;
						cmd.rp_sel      = pta_pkg::RP_CAND;
						state_d         = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/pta_datapath.sv */
// Datapath: request and configuration registers, entry table, scan compare and result registers.
module pta_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  pta_pkg::cmd_t cmd,
	output pta_pkg::sts_t sts,
	input  logic [2:0]    operation,
	input  logic [5:0]    entry,
	input  logic [15:0]   port,
	input  logic [15:0]   remote_port,
	input  logic [31:0]   remote_addr,
	input  logic          privileged,
	input  logic          cfg_wr,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output logic          done,
	output logic [1:0]    status,
	output logic [15:0]   result_port,
	output logic [5:0]    match_entry
);

	localparam int AW = pta_pkg::ADDR_W;
	localparam int CW = pta_pkg::CNT_W;
	localparam int N  = pta_pkg::NUM_ENTRIES;

	// request
	logic [2:0]  op_q;
	logic [5:0]  ent_q;
	logic [15:0] port_q;
	logic [15:0] rport_q;
	logic [31:0] raddr_q;
	logic        priv_q;

	// configuration and cursors
	logic [15:0] gen_base_q, gen_limit_q, priv_base_q, priv_limit_q;
	logic [15:0] gen_cur_q, priv_cur_q;

	// candidate walk
	logic [16:0] cand_q;
	logic        seg1_q;

	// table
	logic [15:0] lp_mem [N];
	logic [15:0] rp_mem [N];
	logic [31:0] ra_mem [N];
	logic [N-1:0] lv_q, rv_q;

	// scan
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [15:0]   rd_lp_s1, rd_rp_s1;
	logic [31:0]   rd_ra_s1;
	logic          rd_lv_s1, rd_rv_s1;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	logic          done_q;
	logic [1:0]    status_q;
	logic [15:0]   result_port_q;
	logic [5:0]    match_entry_q;

	logic [15:0]   cur, base, limit;
	logic [AW-1:0] ent_addr;
	logic [15:0]   rp_eff;
	logic [31:0]   ra_eff;
	logic          match;

	assign cur      = priv_q ? priv_cur_q   : gen_cur_q;
	assign base     = priv_q ? priv_base_q  : gen_base_q;
	assign limit    = priv_q ? priv_limit_q : gen_limit_q;
	assign ent_addr = AW'(ent_q);

	assign rp_eff = rd_rv_s1 ? rd_rp_s1 : 16'd0;
	assign ra_eff = rd_rv_s1 ? rd_ra_s1 : 32'd0;

	always_comb begin
		case (cmd.key)
			pta_pkg::KEY_LOOKUP: match = rd_lv_s1 && (rd_lp_s1 == port_q) &&
				(rp_eff == rport_q) && ((raddr_q == 32'd0) || (ra_eff == raddr_q));
			pta_pkg::KEY_PORT:   match = rd_lv_s1 && (rd_lp_s1 == port_q);
			pta_pkg::KEY_CAND:   match = rd_lv_s1 && (rd_lp_s1 == cand_q[15:0]);
			default:             match = 1'b0;
		endcase
	end

	always_comb begin
		sts.op          = op_q;
		sts.ent_ok      = ({26'd0, ent_q} < 32'(N));
		sts.port_zero   = (port_q == 16'd0);
		sts.scan_done   = (idx_q == CW'(N)) && !rd_vld_s1;
		sts.hit         = hit_q;
		sts.cand_in_seg = seg1_q ? (cand_q <= {1'b0, cur}) : (cand_q < {1'b0, limit});
		sts.cand_zero   = (cand_q == 17'd0);
		sts.seg1        = seg1_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			ent_q   <= entry;
			port_q  <= port;
			rport_q <= remote_port;
			raddr_q <= remote_addr;
			priv_q  <= privileged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_base_q   <= pta_pkg::RESET_GENERAL_BASE;
			gen_limit_q  <= pta_pkg::RESET_GENERAL_LIMIT;
			priv_base_q  <= pta_pkg::RESET_PRIV_BASE;
			priv_limit_q <= pta_pkg::RESET_PRIV_LIMIT;
			gen_cur_q    <= pta_pkg::RESET_GENERAL_BASE - 16'd1;
			priv_cur_q   <= pta_pkg::RESET_PRIV_BASE - 16'd1;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					pta_pkg::CFG_GENERAL_BASE:  gen_base_q   <= cfg_data;
					pta_pkg::CFG_GENERAL_LIMIT: gen_limit_q  <= cfg_data;
					pta_pkg::CFG_PRIV_BASE:     priv_base_q  <= cfg_data;
					pta_pkg::CFG_PRIV_LIMIT:    priv_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.cursor_upd) begin
				if (priv_q) begin
					priv_cur_q <= cand_q[15:0];
				end else begin
					gen_cur_q <= cand_q[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_init) begin
			cand_q <= {1'b0, cur + 16'd1};
			seg1_q <= 1'b0;
		end else if (cmd.cand_seg1) begin
			cand_q <= {1'b0, base};
			seg1_q <= 1'b1;
		end else if (cmd.cand_inc) begin
			cand_q <= cand_q + 17'd1;
		end
	end

	// table storage: entry fields count only while their valid bit is set
	always_ff @(posedge clk) begin
		if (cmd.wr_local) begin
			lp_mem[ent_addr] <= (cmd.rp_sel == pta_pkg::RP_CAND) ? cand_q[15:0] : port_q;
		end
		if (cmd.wr_remote) begin
			rp_mem[ent_addr] <= rport_q;
			ra_mem[ent_addr] <= raddr_q;
		end
		if (cmd.scan_run && (idx_q < CW'(N))) begin
			rd_lp_s1 <= lp_mem[idx_q[AW-1:0]];
			rd_rp_s1 <= rp_mem[idx_q[AW-1:0]];
			rd_ra_s1 <= ra_mem[idx_q[AW-1:0]];
			rd_lv_s1 <= lv_q[idx_q[AW-1:0]];
			rd_rv_s1 <= rv_q[idx_q[AW-1:0]];
			rd_idx_s1 <= idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= '0;
			rv_q <= '0;
		end else begin
			if (cmd.wr_local) begin
				lv_q[ent_addr] <= 1'b1;
			end
			if (cmd.clr_local || cmd.clr_entry) begin
				lv_q[ent_addr] <= 1'b0;
			end
			if (cmd.wr_remote) begin
				rv_q[ent_addr] <= 1'b1;
			end
			if (cmd.clr_entry) begin
				rv_q[ent_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.scan_start) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.scan_run) begin
			if (idx_q < CW'(N)) begin
				idx_q     <= idx_q + CW'(1);
				rd_vld_s1 <= 1'b1;
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			// keep the lowest matching entry
			if (rd_vld_s1 && !hit_q && match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && rd_vld_s1 && !hit_q && match) begin
			hit_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			status_q <= cmd.resp_status;
			case (cmd.rp_sel)
				pta_pkg::RP_PORT: result_port_q <= port_q;
				pta_pkg::RP_CAND: result_port_q <= cand_q[15:0];
				default:          result_port_q <= 16'd0;
			endcase
			match_entry_q <= cmd.me_hit ? 6'(hit_idx_q) : 6'd0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign result_port = result_port_q;
	assign match_entry = match_entry_q;

endmodule

/* rtl/core/port_table_allocator_top.sv */
// Lookup and bind scan every entry before raising done; set, clear, release and ignored
// requests answer straight from decode. Auto bind scans candidates one at a time, skipping
// port zero and changing segment at most once, with at most (held ports + 1) scans. One request
// at a time: busy falls as done rises, and the next request is accepted at the edge that ends
// the strobe; done cannot be held off. Reset empties every entry, loads the register defaults
// and sets each cursor to its base minus one.
module port_table_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [5:0]  entry,
	input  logic [15:0] port,
	input  logic [15:0] remote_port,
	input  logic [31:0] remote_addr,
	input  logic        privileged,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] result_port,
	output logic [5:0]  match_entry,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pta_pkg::cmd_t cmd;
	pta_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	pta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pta_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.entry       (entry),
		.port        (port),
		.remote_port (remote_port),
		.remote_addr (remote_addr),
		.privileged  (privileged),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.result_port (result_port),
		.match_entry (match_entry)
	);

endmodule

/* rtl/core/pta_checker.sv */
// Port-level checks on request/result timing and failed results, bound to the top level.
module pta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] result_port,
	input logic [5:0]  match_entry
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result without a request in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == pta_pkg::ST_IN_USE || status == pta_pkg::ST_EXHAUSTED ||
		status == pta_pkg::ST_MISS) |-> result_port == 16'd0 && match_entry == 6'd0)
		else $error("failed request returned a port or entry");

endmodule

bind port_table_allocator_top pta_checker u_pta_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.result_port (result_port),
	.match_entry (match_entry)
);
